[src/gep_pkg.sv]
// types, config register codes and gf(2^8) multiply for the parity encoder
// no dependencies; imported by every other file of the block
`default_nettype none

package gep_pkg;

  localparam int LANES = 8;
  localparam int ROWS  = 4;
  localparam int CFG_W = 64;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_COEFF_0    = 3'd0;
  localparam cfg_idx_t CFG_COEFF_1    = 3'd1;
  localparam cfg_idx_t CFG_COEFF_2    = 3'd2;
  localparam cfg_idx_t CFG_COEFF_3    = 3'd3;
  localparam cfg_idx_t CFG_ACTIVE_IN  = 3'd4;
  localparam cfg_idx_t CFG_ACTIVE_OUT = 3'd5;
  localparam cfg_idx_t CFG_POLY       = 3'd6;

  localparam logic [3:0] ACTIVE_IN_RST  = 4'd8;
  localparam logic [2:0] ACTIVE_OUT_RST = 3'd4;
  localparam logic [7:0] POLY_RST       = 8'h1d;

  typedef struct packed {
    logic [7:0] data_0;
    logic [7:0] data_1;
    logic [7:0] data_2;
    logic [7:0] data_3;
    logic [7:0] data_4;
    logic [7:0] data_5;
    logic [7:0] data_6;
    logic [7:0] data_7;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] parity_0;
    logic [7:0] parity_1;
    logic [7:0] parity_2;
    logic [7:0] parity_3;
    logic       last_out;
  } out_beat_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // shift-and-xor product reduced by x^8 + poly
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        r = r ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? poly : 8'h00);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/gf256_erasure_parity_encoder.sv]
// Byte-column erasure code encoder over GF(2^8). Each beat carries one byte from each of up
// to eight data shards; each result beat carries one coded byte for each of up to four output
// shards, the xor of coefficient times data byte over the active shards. A chain of
// MAX_INPUTS cells, one per data shard, builds the row sums; a column passes through each
// cell's registers in turn, and the block sustains one beat per cycle while out_stall holds
// no result. The last cell's registers are the output register; when out_stall holds a result
// the whole chain waits. The user must write registers over the cfg port only while no beat
// is in flight; the block does not enforce this. Uses gep_pkg and gep_cell.
`default_nettype none

module gf256_erasure_parity_encoder
  import gep_pkg::*;
#(
  parameter int MAX_INPUTS  = 8,
  parameter int MAX_OUTPUTS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_beat,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_beat,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int NROWS = (MAX_OUTPUTS < ROWS) ? MAX_OUTPUTS : ROWS;

  logic [CFG_W-1:0] coeff_r [NROWS];
  logic [3:0]       active_in_r;
  logic [2:0]       active_out_r;
  logic [7:0]       poly_r;

  for (genvar r = 0; r < NROWS; r++) begin : g_coeff
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coeff_r[r] <= '0;
      end else if (cfg_we && (cfg_index == CFG_COEFF_0 + 3'(r))) begin
        coeff_r[r] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_in_r  <= ACTIVE_IN_RST;
      active_out_r <= ACTIVE_OUT_RST;
      poly_r       <= POLY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_ACTIVE_IN:  active_in_r  <= cfg_wdata[3:0];
        CFG_ACTIVE_OUT: active_out_r <= cfg_wdata[2:0];
        CFG_POLY:       poly_r       <= cfg_wdata[7:0];
        CFG_COEFF_0, CFG_COEFF_1, CFG_COEFF_2, CFG_COEFF_3: ;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [LANES-1:0][7:0] in_lanes;
  assign in_lanes = {in_beat.data_7, in_beat.data_6, in_beat.data_5, in_beat.data_4,
                     in_beat.data_3, in_beat.data_2, in_beat.data_1, in_beat.data_0};

  stage_ctl_t                 ctl_chain  [MAX_INPUTS+1];
  logic [MAX_INPUTS-1:0][7:0] data_chain [MAX_INPUTS+1];
  logic [NROWS-1:0][7:0]      acc_chain  [MAX_INPUTS+1];

  assign ctl_chain[0].valid = in_valid;
  assign ctl_chain[0].last  = in_beat.last_in;
  assign acc_chain[0]       = '0;

  for (genvar i = 0; i < MAX_INPUTS; i++) begin : g_lane
    assign data_chain[0][i] = in_lanes[i];
  end

  for (genvar i = 0; i < MAX_INPUTS; i++) begin : g_cell
    logic [NROWS-1:0][7:0] cell_coeff;
    logic                  lane_on;

    for (genvar r = 0; r < NROWS; r++) begin : g_row
      assign cell_coeff[r] = coeff_r[r][8*i +: 8];
    end
    assign lane_on = (active_in_r > 4'(i));

    gep_cell #(
      .NIN   (MAX_INPUTS),
      .NROWS (NROWS),
      .LANE  (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .lane_on (lane_on),
      .poly    (poly_r),
      .coeff   (cell_coeff),
      .ctl_in  (ctl_chain[i]),
      .data_in (data_chain[i]),
      .acc_in  (acc_chain[i]),
      .ctl_r   (ctl_chain[i+1]),
      .data_r  (data_chain[i+1]),
      .acc_r   (acc_chain[i+1])
    );
  end

  logic [ROWS-1:0][7:0] parity;

  for (genvar k = 0; k < ROWS; k++) begin : g_out
    if (k < NROWS) begin : g_used
      assign parity[k] = (active_out_r > 3'(k)) ? acc_chain[MAX_INPUTS][k] : 8'h00;
    end else begin : g_zero
      assign parity[k] = 8'h00;
    end
  end

  assign out_valid         = ctl_chain[MAX_INPUTS].valid;
  assign out_beat.parity_0 = parity[0];
  assign out_beat.parity_1 = parity[1];
  assign out_beat.parity_2 = parity[2];
  assign out_beat.parity_3 = parity[3];
  assign out_beat.last_out = ctl_chain[MAX_INPUTS].last;

endmodule

`default_nettype wire

[src/gep_cell.sv]
// one cell of the encoder chain: adds its shard's products into the row sums
// uses gep_pkg; instantiated once per data shard by the top level
`default_nettype none

module gep_cell
  import gep_pkg::*;
#(
  parameter int NIN   = 8,
  parameter int NROWS = 4,
  parameter int LANE  = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       lane_on,
  input  wire logic [7:0]                 poly,
  input  wire logic [NROWS-1:0][7:0]      coeff,
  input  wire stage_ctl_t                 ctl_in,
  input  wire logic [NIN-1:0][7:0]        data_in,
  input  wire logic [NROWS-1:0][7:0]      acc_in,
  output stage_ctl_t                      ctl_r,
  output logic [NIN-1:0][7:0]             data_r,
  output logic [NROWS-1:0][7:0]           acc_r
);

  logic [NROWS-1:0][7:0] acc_nxt;

  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      acc_nxt[r] = acc_in[r] ^ (lane_on ? gf_mul(coeff[r], data_in[LANE], poly) : 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_in;
      acc_r  <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

[src/gep_check.sv]
// port-level checks for the parity encoder, bound to the top level
// uses gep_pkg; attached by the bind statement at the end of this file
`default_nettype none

module gep_check
  import gep_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_beat_t out_beat
);

  // result beat held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_beat))
    else $error("result beat changed while stalled");

  // input only backs up when a result is stuck at the output
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with output free");

  // chain is empty the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind gf256_erasure_parity_encoder gep_check u_gep_check (.*);

`default_nettype wire
